@@ design/ffcs_pkg.sv @@
// shared types and constants of the feed first-cut sequencer
package ffcs_pkg;

    localparam int STEP_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W = 11;
    localparam int OFS_W = 8;
    localparam int TARGET_W = 12;
    localparam int DELAY_W = 16;
    localparam int STAMP_W = 32;
    localparam int NMS_W = 2;

    // sequencer steps
    localparam logic [STEP_W-1:0] STEP_RETRACT_FEED_A = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MOVE_FIRST_START = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CLAMP_A = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DELAY_A = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MOVE_FIRST_END = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WAIT_MOTOR = 4'd5;
    localparam logic [STEP_W-1:0] STEP_RETRACT_FEED_B = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MOVE_SECOND_START = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CLAMP_B = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DELAY_B = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MOVE_SECOND_END = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FINISH = 4'd11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_END_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_START_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_END_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MINIS_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_DELAY_MS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MINIS_MODE = 3'd6;

    // machine state requests
    localparam logic [NMS_W-1:0] NMS_STAY = 2'd0;
    localparam logic [NMS_W-1:0] NMS_CUTTING = 2'd1;
    localparam logic [NMS_W-1:0] NMS_IDLE = 2'd2;

    // register reset values
    localparam logic [POS_W-1:0] RST_FIRST_START_POS = 11'h788;   // -120
    localparam logic [POS_W-1:0] RST_FIRST_END_POS = 11'd340;
    localparam logic [POS_W-1:0] RST_SECOND_START_POS = 11'h788;  // -120
    localparam logic [POS_W-1:0] RST_SECOND_END_POS = 11'h7fb;    // -5
    localparam logic [OFS_W-1:0] RST_MINIS_OFFSET = 8'he7;        // -25
    localparam logic [DELAY_W-1:0] RST_CLAMP_DELAY_MS = 16'd400;

    typedef struct packed {
        logic [POS_W-1:0]   first_start_pos;
        logic [POS_W-1:0]   first_end_pos;
        logic [POS_W-1:0]   second_start_pos;
        logic [POS_W-1:0]   second_end_pos;
        logic [OFS_W-1:0]   minis_offset;
        logic [DELAY_W-1:0] clamp_delay_ms;
        logic               minis_mode;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [STAMP_W-1:0] time_ms;
        logic               motor_ready;
        logic               no_wood_clear;
        logic               start_switch_on;
    } item_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step_now;
        logic                feed_clamp_retract;
        logic                extend_feed_clamp;
        logic                retract_top_clamp;
        logic                move_valid;
        logic [TARGET_W-1:0] move_target;
        logic                set_start_safe;
        logic                clear_no_wood;
        logic [NMS_W-1:0]    next_machine_state;
    } res_t;

endpackage

@@ design/feed_first_cut_sequencer_core.sv @@
// top level of the feed first-cut sequencer: input stage, step state and result register
//
//  channel | direction | ports                                   | content
//  --------+-----------+-----------------------------------------+----------------------------
//  s_      | in        | s_tvalid s_tready s_tdata[39:0] s_tuser | poll or reset item
//  m_      | out       | m_tvalid m_tready m_tdata[23:0]         | one result beat per item
//  cfg_    | in        | cfg_we cfg_index[2:0] cfg_data[15:0]    | register writes, no read-back
//
// one beat per cycle sustained while the m_ side is ready; an input beat lands in the
// input register, the step logic works on it combinationally and the result lands in
// the output register
// aresetn is synchronous, active low: step 0, timer mark 0, registers to defaults
// a stalled m_ side holds the result; the input register keeps taking a beat as long
// as the result register is free or being drained in the same cycle
module feed_first_cut_sequencer_core
    import ffcs_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] time_ms, [32] motor_ready, [33] no_wood_clear, [34] start_switch_on, [39:35] zero
    input  logic [39:0]           s_tdata,
    // [0] mode: 0 poll, 1 enter or exit reset
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] step_now, [4] feed_clamp_retract, [5] extend_feed_clamp, [6] retract_top_clamp,
    // [7] move_valid, [19:8] move_target, [20] set_start_safe, [21] clear_no_wood,
    // [23:22] next_machine_state
    output logic [23:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg;
    item_t                item_reg;
    logic                 in_valid_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [TIME_BITS-1:0] wait_start_reg;
    logic [TIME_BITS-1:0] wait_start_next;
    res_t                 res_next;
    res_t                 res_reg;
    logic                 out_valid_reg;
    logic                 advance_item;

    ffcs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffcs_step_logic #(
        .TIME_BITS (TIME_BITS)
    ) u_step_logic (
        .item            (item_reg),
        .cfg             (cfg),
        .step            (step_reg),
        .wait_start      (wait_start_reg),
        .step_next       (step_next),
        .wait_start_next (wait_start_next),
        .res             (res_next)
    );

    // item in the input register moves on when the result register can take it
    assign advance_item = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance_item;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg <= STEP_RETRACT_FEED_A;
            wait_start_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance_item) begin
                out_valid_reg <= 1'b1;
                step_reg <= step_next;
                wait_start_reg <= wait_start_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.mode <= s_tuser;
            item_reg.time_ms <= s_tdata[31:0];
            item_reg.motor_ready <= s_tdata[32];
            item_reg.no_wood_clear <= s_tdata[33];
            item_reg.start_switch_on <= s_tdata[34];
        end
        if (advance_item) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {res_reg.next_machine_state,
                      res_reg.clear_no_wood,
                      res_reg.set_start_safe,
                      res_reg.move_target,
                      res_reg.move_valid,
                      res_reg.retract_top_clamp,
                      res_reg.extend_feed_clamp,
                      res_reg.feed_clamp_retract,
                      res_reg.step_now};

endmodule

@@ design/ffcs_cfg_regs.sv @@
// configuration register file of the feed sequencer
module ffcs_cfg_regs
    import ffcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_START_POS:  cfg_next.first_start_pos = cfg_data[POS_W-1:0];
                REG_FIRST_END_POS:    cfg_next.first_end_pos = cfg_data[POS_W-1:0];
                REG_SECOND_START_POS: cfg_next.second_start_pos = cfg_data[POS_W-1:0];
                REG_SECOND_END_POS:   cfg_next.second_end_pos = cfg_data[POS_W-1:0];
                REG_MINIS_OFFSET:     cfg_next.minis_offset = cfg_data[OFS_W-1:0];
                REG_CLAMP_DELAY_MS:   cfg_next.clamp_delay_ms = cfg_data[DELAY_W-1:0];
                REG_MINIS_MODE:       cfg_next.minis_mode = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_start_pos <= RST_FIRST_START_POS;
            cfg_reg.first_end_pos <= RST_FIRST_END_POS;
            cfg_reg.second_start_pos <= RST_SECOND_START_POS;
            cfg_reg.second_end_pos <= RST_SECOND_END_POS;
            cfg_reg.minis_offset <= RST_MINIS_OFFSET;
            cfg_reg.clamp_delay_ms <= RST_CLAMP_DELAY_MS;
            cfg_reg.minis_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/ffcs_step_logic.sv @@
// one sequencer step: next step, timer mark and result beat
module ffcs_step_logic
    import ffcs_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  item_t                item,
    input  cfg_t                 cfg,
    input  logic [STEP_W-1:0]    step,
    input  logic [TIME_BITS-1:0] wait_start,
    output logic [STEP_W-1:0]    step_next,
    output logic [TIME_BITS-1:0] wait_start_next,
    output res_t                 res
);

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] elapsed;
    logic                 delay_done;
    logic [TARGET_W-1:0]  second_end;

    assign now = TIME_BITS'(item.time_ms);
    assign elapsed = now - wait_start;
    assign delay_done = elapsed >= TIME_BITS'(cfg.clamp_delay_ms);

    // second end, shifted by the offset in minis mode
    assign second_end = {cfg.second_end_pos[POS_W-1], cfg.second_end_pos}
        + (cfg.minis_mode ? {{(TARGET_W-OFS_W){cfg.minis_offset[OFS_W-1]}}, cfg.minis_offset}
                          : {TARGET_W{1'b0}});

    always_comb begin
        logic advance;
        advance = 1'b0;
        res = '0;
        step_next = step;
        wait_start_next = wait_start;
        if (item.mode) begin
            step_next = STEP_RETRACT_FEED_A;
            wait_start_next = '0;
        end else begin
            case (step)
                STEP_RETRACT_FEED_A, STEP_RETRACT_FEED_B: begin
                    res.feed_clamp_retract = 1'b1;
                    advance = 1'b1;
                end
                STEP_MOVE_FIRST_START: begin
                    if (item.motor_ready) begin
                        res.move_valid = 1'b1;
                        res.move_target = {cfg.first_start_pos[POS_W-1], cfg.first_start_pos};
                        advance = 1'b1;
                    end
                end
                STEP_MOVE_FIRST_END: begin
                    if (item.motor_ready) begin
                        res.move_valid = 1'b1;
                        res.move_target = {cfg.first_end_pos[POS_W-1], cfg.first_end_pos};
                        advance = 1'b1;
                    end
                end
                STEP_MOVE_SECOND_START: begin
                    if (item.motor_ready) begin
                        res.move_valid = 1'b1;
                        res.move_target = {cfg.second_start_pos[POS_W-1],
                                           cfg.second_start_pos};
                        advance = 1'b1;
                    end
                end
                STEP_MOVE_SECOND_END: begin
                    if (item.motor_ready) begin
                        res.move_valid = 1'b1;
                        res.move_target = second_end;
                        advance = 1'b1;
                    end
                end
                STEP_CLAMP_A, STEP_CLAMP_B: begin
                    if (item.motor_ready) begin
                        res.extend_feed_clamp = 1'b1;
                        // top clamp stays put on the first run when leaving no-wood
                        res.retract_top_clamp = (step == STEP_CLAMP_B) || !item.no_wood_clear;
                        advance = 1'b1;
                    end
                end
                STEP_DELAY_A, STEP_DELAY_B: begin
                    advance = delay_done;
                end
                STEP_WAIT_MOTOR: begin
                    advance = item.motor_ready;
                end
                STEP_FINISH: begin
                    if (item.motor_ready) begin
                        res.set_start_safe = 1'b1;
                        res.clear_no_wood = 1'b1;
                        if (item.start_switch_on) begin
                            res.next_machine_state = NMS_CUTTING;
                            res.extend_feed_clamp = 1'b1;
                        end else begin
                            res.next_machine_state = NMS_IDLE;
                        end
                        step_next = STEP_RETRACT_FEED_A;
                        wait_start_next = '0;
                    end
                end
                default: begin
                    step_next = step;
                end
            endcase
            // any advance clears the timer mark, including out of the clamp steps
            if (advance) begin
                step_next = step + 1'b1;
                wait_start_next = '0;
            end
        end
        res.step_now = step_next;
    end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the feed first-cut sequencer core
`timescale 1ns / 100ps

module testbench;
    import ffcs_pkg::*;

    // register index past the end of the register file, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 265;
    localparam int HOLD_LEN = 64;
    // cycles with no beat and no register write before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // expected behavior of the sequencer plus the queue of results still owed
    class step_tracker;
        logic [POS_W-1:0]   first_start;
        logic [POS_W-1:0]   first_end;
        logic [POS_W-1:0]   second_start;
        logic [POS_W-1:0]   second_end;
        logic [OFS_W-1:0]   minis_ofs;
        logic [DELAY_W-1:0] clamp_delay;
        logic               minis_on;
        logic [STEP_W-1:0]  seq_step;
        logic [STAMP_W-1:0] delay_mark;
        res_t               pending_results[$];
        int                 errors;

        function new();
            first_start = POS_W'(-120);
            first_end = POS_W'(340);
            second_start = POS_W'(-120);
            second_end = POS_W'(-5);
            minis_ofs = OFS_W'(-25);
            clamp_delay = DELAY_W'(400);
            minis_on = 1'b0;
            seq_step = STEP_RETRACT_FEED_A;
            delay_mark = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FIRST_START_POS:  first_start = data[POS_W-1:0];
                REG_FIRST_END_POS:    first_end = data[POS_W-1:0];
                REG_SECOND_START_POS: second_start = data[POS_W-1:0];
                REG_SECOND_END_POS:   second_end = data[POS_W-1:0];
                REG_MINIS_OFFSET:     minis_ofs = data[OFS_W-1:0];
                REG_CLAMP_DELAY_MS:   clamp_delay = data[DELAY_W-1:0];
                REG_MINIS_MODE:       minis_on = data[0];
                default: ;
            endcase
        endfunction

        // every advance also drops the timer mark
        function void step_on();
            seq_step = seq_step + 1'b1;
            delay_mark = '0;
        endfunction

        function void predict_item(item_t it);
            res_t               want;
            int                 target;
            logic [STAMP_W-1:0] waited;
            want = '0;
            target = 0;
            if (it.mode) begin
                seq_step = STEP_RETRACT_FEED_A;
                delay_mark = '0;
            end else begin
                case (seq_step)
                    STEP_RETRACT_FEED_A, STEP_RETRACT_FEED_B: begin
                        want.feed_clamp_retract = 1'b1;
                        step_on();
                    end
                    STEP_MOVE_FIRST_START, STEP_MOVE_FIRST_END,
                    STEP_MOVE_SECOND_START, STEP_MOVE_SECOND_END: begin
                        if (it.motor_ready) begin
                            case (seq_step)
                                STEP_MOVE_FIRST_START:  target = $signed(first_start);
                                STEP_MOVE_FIRST_END:    target = $signed(first_end);
                                STEP_MOVE_SECOND_START: target = $signed(second_start);
                                default: begin
                                    target = $signed(second_end);
                                    if (minis_on) target += $signed(minis_ofs);
                                end
                            endcase
                            want.move_valid = 1'b1;
                            want.move_target = TARGET_W'(target);
                            step_on();
                        end
                    end
                    STEP_CLAMP_A, STEP_CLAMP_B: begin
                        if (it.motor_ready) begin
                            want.extend_feed_clamp = 1'b1;
                            want.retract_top_clamp = (seq_step == STEP_CLAMP_B) ||
                                                     !it.no_wood_clear;
                            // no stamp is taken here and the advance clears the mark, so the
                            // delay step measures from time zero
                            step_on();
                        end
                    end
                    STEP_DELAY_A, STEP_DELAY_B: begin
                        waited = it.time_ms - delay_mark;
                        if (waited >= STAMP_W'(clamp_delay)) step_on();
                    end
                    STEP_WAIT_MOTOR: begin
                        if (it.motor_ready) step_on();
                    end
                    STEP_FINISH: begin
                        if (it.motor_ready) begin
                            want.set_start_safe = 1'b1;
                            want.clear_no_wood = 1'b1;
                            if (it.start_switch_on) begin
                                want.next_machine_state = NMS_CUTTING;
                                want.extend_feed_clamp = 1'b1;
                            end else begin
                                want.next_machine_state = NMS_IDLE;
                            end
                            seq_step = STEP_RETRACT_FEED_A;
                            delay_mark = '0;
                        end
                    end
                    default: ;
                endcase
            end
            want.step_now = seq_step;
            pending_results.push_back(want);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task cmp_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %0h, expected %0h", field, got, want));
        endtask

        task check_result(logic [23:0] beat);
            res_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result beat %h with nothing outstanding", beat));
                return;
            end
            want = pending_results.pop_front();
            cmp_field("step_now", beat[3:0], want.step_now);
            cmp_field("feed_clamp_retract", beat[4], want.feed_clamp_retract);
            cmp_field("extend_feed_clamp", beat[5], want.extend_feed_clamp);
            cmp_field("retract_top_clamp", beat[6], want.retract_top_clamp);
            cmp_field("move_valid", beat[7], want.move_valid);
            cmp_field("move_target", beat[19:8], want.move_target);
            cmp_field("set_start_safe", beat[20], want.set_start_safe);
            cmp_field("clear_no_wood", beat[21], want.clear_no_wood);
            cmp_field("next_machine_state", beat[23:22], want.next_machine_state);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] time_ms, [32] motor_ready, [33] no_wood_clear, [34] start_switch_on, [39:35] zero
    logic [39:0]           s_tdata = '0;
    // [0] mode
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [3:0] step_now, [4] feed_clamp_retract, [5] extend_feed_clamp, [6] retract_top_clamp,
    // [7] move_valid, [19:8] move_target, [20] set_start_safe, [21] clear_no_wood,
    // [23:22] next_machine_state
    logic [23:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // idle percentages per side, switched by the stimulus between phases
    int tx_idle_pct = 36;
    int rx_idle_pct = 80;
    // raised by the stimulus, dropped by the receiver once its long hold is over
    bit hold_pending = 1'b0;

    step_tracker sb = new();

    feed_first_cut_sequencer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // offer one beat after a random gap and wait until it is taken; valid stays
    // high into the next beat when no gap follows
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.start_switch_on, it.no_wood_clear, it.motor_ready, it.time_ms};
        s_tuser <= it.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_item(it);
    endtask

    task automatic put(input bit mode, input logic [STAMP_W-1:0] stamp, input bit ready,
                       input bit nw, input bit sw);
        item_t it;
        it.mode = mode;
        it.time_ms = stamp;
        it.motor_ready = ready;
        it.no_wood_clear = nw;
        it.start_switch_on = sw;
        send_item(it);
    endtask

    // stop offering and wait for every owed result; each beat yields exactly one
    // result, so an empty queue means the core holds nothing
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // write all registers back to back, unused upper data bits carry junk,
    // and finish with a write to the unused index
    task automatic program_regs(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        vals[REG_FIRST_START_POS] = {junk[15:11], c.first_start_pos};
        vals[REG_FIRST_END_POS] = {junk[15:11], c.first_end_pos};
        vals[REG_SECOND_START_POS] = {junk[15:11], c.second_start_pos};
        vals[REG_SECOND_END_POS] = {junk[15:11], c.second_end_pos};
        vals[REG_MINIS_OFFSET] = {junk[15:8], c.minis_offset};
        vals[REG_CLAMP_DELAY_MS] = c.clamp_delay_ms;
        vals[REG_MINIS_MODE] = {junk[15:1], c.minis_mode};
        vals[REG_UNUSED] = ~junk;
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // kind 0: every value at its low end, kind 1: at its high end, both with minis mode on, else random
    function automatic cfg_t make_cfg(int kind);
        cfg_t c;
        case (kind)
            0: begin
                c.first_start_pos = POS_W'(-1000);
                c.first_end_pos = POS_W'(-1000);
                c.second_start_pos = POS_W'(-1000);
                c.second_end_pos = POS_W'(-1000);
                c.minis_offset = OFS_W'(-100);
                c.clamp_delay_ms = '0;
                c.minis_mode = 1'b1;
            end
            1: begin
                c.first_start_pos = POS_W'(1000);
                c.first_end_pos = POS_W'(1000);
                c.second_start_pos = POS_W'(1000);
                c.second_end_pos = POS_W'(1000);
                c.minis_offset = OFS_W'(100);
                c.clamp_delay_ms = 16'hffff;
                c.minis_mode = 1'b1;
            end
            default: begin
                c.first_start_pos = POS_W'($urandom_range(0, 2000) - 1000);
                c.first_end_pos = POS_W'($urandom_range(0, 2000) - 1000);
                c.second_start_pos = POS_W'($urandom_range(0, 2000) - 1000);
                c.second_end_pos = POS_W'($urandom_range(0, 2000) - 1000);
                c.minis_offset = OFS_W'($urandom_range(0, 200) - 100);
                c.clamp_delay_ms = DELAY_W'($urandom_range(0, 2000));
                c.minis_mode = 1'($urandom_range(0, 1));
            end
        endcase
        return c;
    endfunction

    // mostly polls with the motor ready so runs walk through all twelve steps;
    // stray reset items break runs, and stamps cluster around the clamp delay
    function automatic item_t rand_item(logic [DELAY_W-1:0] delay);
        item_t it;
        it.mode = ($urandom_range(0, 99) < 3);
        it.motor_ready = ($urandom_range(0, 99) < 75);
        it.no_wood_clear = 1'($urandom_range(0, 1));
        it.start_switch_on = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: it.time_ms = delay + $urandom_range(0, 4) - 2;
            1: it.time_ms = $urandom_range(0, delay);
            default: it.time_ms = $urandom;
        endcase
        return it;
    endfunction

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk through one full run on reset register values
        put(1, 32'hffff_ffff, 1, 1, 1);   // reset beat with every flag up
        put(0, 0, 0, 0, 0);               // retract feed clamp, motor not needed
        put(0, 5, 0, 1, 1);               // move blocked, motor busy
        put(0, 6, 1, 0, 0);               // move to first start
        put(0, 7, 1, 1, 0);               // clamp with no-wood clear: top clamp stays
        put(0, 399, 1, 0, 0);             // one short of the delay, counted from zero
        put(0, 400, 0, 0, 0);             // delay met exactly
        put(0, 401, 0, 0, 0);             // first end move blocked
        put(0, 402, 1, 0, 0);             // move to first end
        put(0, 403, 0, 0, 0);             // waiting for motor
        put(0, 404, 1, 0, 0);
        put(0, 405, 0, 1, 1);             // second feed clamp retract
        put(0, 406, 1, 0, 0);             // move to second start
        put(0, 407, 1, 1, 0);             // second clamp retracts top clamp regardless
        put(0, 32'hffff_ffff, 0, 0, 0);   // top stamp passes the delay
        put(0, 0, 1, 0, 0);               // move to second end
        put(0, 1, 0, 0, 1);               // finish blocked
        put(0, 2, 1, 0, 1);               // finish with switch on: cutting plus clamp
        put(0, 3, 1, 0, 0);
        put(0, 4, 1, 0, 0);
        put(0, 5, 1, 0, 0);               // clamp without no-wood clear: top clamp
        put(1, 0, 0, 0, 0);               // reset beat mid-run

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase == 2) begin
                tx_idle_pct = 80;
                rx_idle_pct = 36;
            end else if (phase == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_regs(make_cfg(phase));
            // long receiver hold while the sender keeps pushing, fills the core
            if (phase == 4) hold_pending = 1'b1;
            repeat (PHASE_ITEMS) send_item(rand_item(sb.clamp_delay));
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side ready: random stalls, or one long counted hold on request
    initial begin : receiver
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                m_tready <= 1'b0;
                held++;
                if (held == HOLD_LEN) begin
                    hold_pending = 1'b0;
                    held = 0;
                end
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // every accepted result beat is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // hang detection: too long without any beat or register write
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ feed_first_cut_sequencer_core.f @@
design/ffcs_pkg.sv
design/ffcs_cfg_regs.sv
design/ffcs_step_logic.sv
design/feed_first_cut_sequencer_core.sv
tb/testbench.sv
